[rtl/lecmd_pkg.sv]
// package for the line editor command hash matcher
// constants, byte codes, message tables and controller state type
`timescale 1ns / 1ps

package lecmd_pkg;

	localparam int unsigned LINE_BYTES_DEF    = 64;
	localparam int unsigned COMMAND_SLOTS_DEF = 6;
	localparam int unsigned MAX_SLOTS         = 6;
	localparam int unsigned HASH_W            = 32;
	localparam int unsigned CFG_IDX_W         = 3;
	localparam logic [HASH_W-1:0] SEED_RESET  = 32'd5381;

	localparam logic [CFG_IDX_W-1:0] REG_SEED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd7;

	localparam logic [1:0] KIND_TX    = 2'd0;
	localparam logic [1:0] KIND_FOUND = 2'd1;
	localparam logic [1:0] KIND_MISS  = 2'd2;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_DEL = 8'h7F;

	// message select for the transmit sequencer
	typedef enum logic [1:0] {
		MSG_ERASE,
		MSG_WIPE,
		MSG_UNKNOWN
	} msg_t;

	localparam logic [4:0] ERASE_LEN   = 5'd3;
	localparam logic [4:0] WIPE_LEN    = 5'd7;
	localparam logic [4:0] UNKNOWN_LEN = 5'd17;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ECHO,
		ST_SKIP,
		ST_HASH,
		ST_MUL,
		ST_CR,
		ST_LF,
		ST_RESULT,
		ST_MSG
	} state_t;

	// controller commands to the datapath
	typedef struct packed {
		logic       store_byte;
		logic       dec_fill;
		logic       clr_fill;
		logic       rd_req;
		logic       ptr_clr;
		logic       ptr_inc;
		logic       hash_seed;
		logic       hash_mul;
		logic       hash_add;
		logic       hash_zero;
		logic       msg_clr;
		logic       msg_inc;
	} dp_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic       empty;
		logic       full;
		logic       ptr_end;
		logic       rd_space;
		logic       rd_nul;
		logic       any_match;
		logic       msg_end;
	} dp_sts_t;

	function automatic logic [7:0] msg_byte(input msg_t m, input logic [4:0] i);
		logic [7:0] b;
		b = CH_NUL;
		case (m)
			MSG_ERASE: begin
				case (i)
					5'd1:    b = CH_SP;
					default: b = CH_BS;
				endcase
			end
			MSG_WIPE: begin
				case (i)
					5'd0, 5'd4: b = 8'h1B;
					5'd1, 5'd5: b = 8'h5B;
					5'd2:       b = 8'h31;
					5'd3:       b = 8'h4A;
					default:    b = 8'h48;
				endcase
			end
			default: begin
				case (i)
					5'd0:    b = 8'h55;
					5'd1:    b = 8'h6E;
					5'd2:    b = 8'h6B;
					5'd3:    b = 8'h6E;
					5'd4:    b = 8'h6F;
					5'd5:    b = 8'h77;
					5'd6:    b = 8'h6E;
					5'd7:    b = CH_SP;
					5'd8:    b = 8'h63;
					5'd9:    b = 8'h6F;
					5'd10:   b = 8'h6D;
					5'd11:   b = 8'h6D;
					5'd12:   b = 8'h61;
					5'd13:   b = 8'h6E;
					5'd14:   b = 8'h64;
					5'd15:   b = CH_CR;
					default: b = CH_LF;
				endcase
			end
		endcase
		return b;
	endfunction

	function automatic logic [4:0] msg_len(input msg_t m);
		logic [4:0] l;
		case (m)
			MSG_ERASE: l = ERASE_LEN;
			MSG_WIPE:  l = WIPE_LEN;
			default:   l = UNKNOWN_LEN;
		endcase
		return l;
	endfunction

endpackage

[rtl/lecmd_if.sv]
// valid/ready channel interface with payload type parameter
// used by the line editor command hash matcher ports
`timescale 1ns / 1ps

interface lecmd_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/lecmd_datapath.sv]
// datapath: line store, fill count, read pointer, hash register, match compare
// depends on lecmd_pkg
`timescale 1ns / 1ps

module lecmd_datapath #(
	parameter int unsigned LINE_BYTES    = lecmd_pkg::LINE_BYTES_DEF,
	parameter int unsigned COMMAND_SLOTS = lecmd_pkg::COMMAND_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [7:0]                          rx_byte,
	input  lecmd_pkg::dp_cmd_t                  cmd,
	input  lecmd_pkg::msg_t                     msg_sel,
	input  logic [lecmd_pkg::HASH_W-1:0]        seed,
	input  logic [lecmd_pkg::HASH_W*lecmd_pkg::MAX_SLOTS-1:0] cmd_hashes,
	input  logic [lecmd_pkg::MAX_SLOTS-1:0]     slot_en,
	output lecmd_pkg::dp_sts_t                  sts,
	output logic [7:0]                          msg_out,
	output logic [lecmd_pkg::HASH_W-1:0]        hash_out,
	output logic [lecmd_pkg::MAX_SLOTS-1:0]     mask_out
);
	localparam int unsigned AW = $clog2(LINE_BYTES);
	localparam int unsigned CW = AW + 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(LINE_BYTES - 1);

	logic [7:0]                  mem [LINE_BYTES];
	logic [CW-1:0]               fill_q;
	logic [CW-1:0]               ptr_q;
	logic [7:0]                  rd_q;
	logic [lecmd_pkg::HASH_W-1:0] hash_q;
	logic [lecmd_pkg::HASH_W-1:0] prod_q;
	logic [4:0]                  msg_q;

	always_ff @(posedge clk) begin
		if (cmd.store_byte) begin
			mem[fill_q[AW-1:0]] <= rx_byte;
		end
		if (cmd.rd_req) begin
			rd_q <= mem[ptr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ptr_q  <= '0;
			msg_q  <= '0;
		end else begin
			if (cmd.clr_fill) begin
				fill_q <= '0;
			end else if (cmd.store_byte) begin
				fill_q <= fill_q + CW'(1);
			end else if (cmd.dec_fill) begin
				fill_q <= fill_q - CW'(1);
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.msg_clr) begin
				msg_q <= '0;
			end else if (cmd.msg_inc) begin
				msg_q <= msg_q + 5'd1;
			end
		end
	end

	// hash = hash*33 + byte, split into shift-add then add
	always_ff @(posedge clk) begin
		if (cmd.hash_mul) begin
			prod_q <= {hash_q[lecmd_pkg::HASH_W-6:0], 5'd0} + hash_q;
		end
		if (cmd.hash_zero) begin
			hash_q <= '0;
		end else if (cmd.hash_seed) begin
			hash_q <= seed;
		end else if (cmd.hash_add) begin
			hash_q <= prod_q + {24'd0, rd_q};
		end
	end

	always_comb begin
		mask_out = '0;
		for (int s = 0; s < COMMAND_SLOTS; s++) begin
			mask_out[s] = slot_en[s] &&
				(cmd_hashes[s*lecmd_pkg::HASH_W +: lecmd_pkg::HASH_W] == hash_q);
		end
	end

	assign hash_out = hash_q;
	assign msg_out  = lecmd_pkg::msg_byte(msg_sel, msg_q);

	assign sts.empty     = (fill_q == '0);
	assign sts.full      = (fill_q >= FULL_CNT);
	assign sts.ptr_end   = (ptr_q >= fill_q);
	assign sts.rd_space  = (rd_q == lecmd_pkg::CH_SP);
	assign sts.rd_nul    = (rd_q == lecmd_pkg::CH_NUL);
	assign sts.any_match = |mask_out;
	assign sts.msg_end   = (msg_q == lecmd_pkg::msg_len(msg_sel) - 5'd1);

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT) else $error("fill count above line limit");
	a_store_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_byte |-> !sts.full) else $error("store into full line");
	a_dec_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec_fill |-> !sts.empty) else $error("erase on empty line");
`endif
endmodule

[rtl/lecmd_ctrl.sv]
// controller state machine: decodes the byte, sequences hashing and output items
// depends on lecmd_pkg
`timescale 1ns / 1ps

module lecmd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	input  lecmd_pkg::dp_sts_t  sts,
	output lecmd_pkg::dp_cmd_t  cmd,
	output lecmd_pkg::msg_t     msg_sel,
	output logic                out_load,
	output logic [1:0]          out_kind,
	output logic                out_last,
	output logic                out_use_msg,
	output logic [7:0]          out_lit,
	input  logic                out_free
);
	lecmd_pkg::state_t state_q, state_d;
	lecmd_pkg::msg_t   msg_q, msg_d;
	logic              any_tok_q, any_tok_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lecmd_pkg::ST_IDLE;
			msg_q     <= lecmd_pkg::MSG_ERASE;
			any_tok_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			msg_q     <= msg_d;
			any_tok_q <= any_tok_d;
		end
	end

	assign msg_sel = msg_q;

	always_comb begin
		logic acc;
		state_d     = state_q;
		msg_d       = msg_q;
		any_tok_d   = any_tok_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_load    = 1'b0;
		out_kind    = lecmd_pkg::KIND_TX;
		out_last    = 1'b0;
		out_use_msg = 1'b0;
		out_lit     = rx_byte;
		acc         = 1'b0;
		case (state_q)
			lecmd_pkg::ST_IDLE: begin
				in_ready = out_free;
				acc      = in_valid && out_free;
				if (acc) begin
					case (rx_byte)
						lecmd_pkg::CH_CR, lecmd_pkg::CH_LF: begin
							cmd.ptr_clr   = 1'b1;
							cmd.hash_zero = 1'b1;
							any_tok_d     = 1'b0;
							state_d       = lecmd_pkg::ST_CR;
						end
						lecmd_pkg::CH_BS, lecmd_pkg::CH_DEL: begin
							if (!sts.empty) begin
								cmd.dec_fill = 1'b1;
								cmd.msg_clr  = 1'b1;
								msg_d        = lecmd_pkg::MSG_ERASE;
								state_d      = lecmd_pkg::ST_MSG;
							end
						end
						lecmd_pkg::CH_ETX: begin
							cmd.clr_fill = 1'b1;
							if (!sts.empty) begin
								cmd.msg_clr = 1'b1;
								msg_d       = lecmd_pkg::MSG_WIPE;
								state_d     = lecmd_pkg::ST_MSG;
							end
						end
						default: begin
							if (!sts.full) begin
								cmd.store_byte = 1'b1;
								out_load       = 1'b1;
								out_last       = 1'b1;
							end
						end
					endcase
				end
			end
			lecmd_pkg::ST_CR: begin
				// pointer is at line start here, fetch the first byte
				cmd.rd_req = 1'b1;
				if (out_free) begin
					out_load = 1'b1;
					out_lit  = lecmd_pkg::CH_CR;
					state_d  = lecmd_pkg::ST_LF;
				end
			end
			lecmd_pkg::ST_LF: begin
				if (out_free) begin
					out_load = 1'b1;
					out_lit  = lecmd_pkg::CH_LF;
					state_d  = lecmd_pkg::ST_SKIP;
				end
			end
			// rd byte at ptr is valid here
			lecmd_pkg::ST_SKIP: begin
				if (sts.ptr_end || sts.rd_nul) begin
					state_d = lecmd_pkg::ST_RESULT;
				end else if (sts.rd_space) begin
					cmd.ptr_inc = 1'b1;
					state_d     = lecmd_pkg::ST_ECHO;
				end else begin
					cmd.hash_seed = 1'b1;
					state_d       = lecmd_pkg::ST_MUL;
				end
			end
			// read wait after a pointer step, while skipping spaces or hashing a token
			lecmd_pkg::ST_ECHO: begin
				cmd.rd_req = 1'b1;
				state_d    = any_tok_q ? lecmd_pkg::ST_MUL : lecmd_pkg::ST_SKIP;
			end
			lecmd_pkg::ST_MUL: begin
				cmd.hash_mul = 1'b1;
				any_tok_d    = 1'b1;
				state_d      = lecmd_pkg::ST_HASH;
				if (any_tok_q) begin
					if (sts.ptr_end || sts.rd_nul || sts.rd_space) begin
						cmd.hash_mul = 1'b0;
						state_d      = lecmd_pkg::ST_RESULT;
					end
				end
			end
			lecmd_pkg::ST_HASH: begin
				cmd.hash_add = 1'b1;
				cmd.ptr_inc  = 1'b1;
				state_d      = lecmd_pkg::ST_ECHO;
			end
			lecmd_pkg::ST_RESULT: begin
				if (out_free) begin
					out_load     = 1'b1;
					cmd.clr_fill = 1'b1;
					if (sts.any_match) begin
						out_kind = lecmd_pkg::KIND_FOUND;
						out_last = 1'b1;
						state_d  = lecmd_pkg::ST_IDLE;
					end else begin
						out_kind    = lecmd_pkg::KIND_MISS;
						cmd.msg_clr = 1'b1;
						msg_d       = lecmd_pkg::MSG_UNKNOWN;
						state_d     = lecmd_pkg::ST_MSG;
					end
				end
			end
			lecmd_pkg::ST_MSG: begin
				if (out_free) begin
					out_load    = 1'b1;
					out_use_msg = 1'b1;
					cmd.msg_inc = 1'b1;
					if (sts.msg_end) begin
						out_last = 1'b1;
						state_d  = lecmd_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = lecmd_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == lecmd_pkg::ST_IDLE) else $error("ready outside idle");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free) else $error("output overwrite");
	a_hash_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hash_add |=> state_q == lecmd_pkg::ST_ECHO) else $error("hash walk order");
`endif
endmodule

[rtl/line_editor_command_hash_matcher_core.sv]
// An ordinary byte is echoed into the output register as it is taken; backspace, Ctrl-C send 3 or 7 items.
// End of line: CR, LF, then each token byte is read from the line store and passed through the shared
// multiply-by-33 unit, then 1 or 18 result items.
// One item at a time: the next byte is taken when the sequence of the last has gone out.
// Reset clears fill count and controller state; seed resets to 5381, hashes and enables to 0.
// No clearing pass: only line store bytes below the fill count are used.
`timescale 1ns / 1ps

module line_editor_command_hash_matcher_core #(
	parameter int unsigned LINE_BYTES    = lecmd_pkg::LINE_BYTES_DEF,
	parameter int unsigned COMMAND_SLOTS = lecmd_pkg::COMMAND_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	lecmd_if.sink                              rx,
	lecmd_if.source                            res,
	input  logic                               cfg_we,
	input  logic [lecmd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lecmd_pkg::HASH_W-1:0]       cfg_data
);
	logic [lecmd_pkg::HASH_W-1:0]                       seed_q;
	logic [lecmd_pkg::HASH_W*lecmd_pkg::MAX_SLOTS-1:0]  hashes_q;
	logic [lecmd_pkg::MAX_SLOTS-1:0]                    enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= lecmd_pkg::SEED_RESET;
			hashes_q <= '0;
			enable_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lecmd_pkg::REG_SEED:   seed_q <= cfg_data;
				lecmd_pkg::REG_ENABLE: enable_q <= cfg_data[lecmd_pkg::MAX_SLOTS-1:0];
				default: begin
					hashes_q[(32'(cfg_index) - 1) * lecmd_pkg::HASH_W +: lecmd_pkg::HASH_W]
						<= cfg_data;
				end
			endcase
		end
	end

	lecmd_pkg::dp_cmd_t cmd;
	lecmd_pkg::dp_sts_t sts;
	lecmd_pkg::msg_t    msg_sel;
	logic [7:0]         msg_out;
	logic [31:0]        hash_out;
	logic [5:0]         mask_out;
	logic               out_load, out_last, out_use_msg, out_free;
	logic [1:0]         out_kind;
	logic [7:0]         out_lit;

	lecmd_datapath #(.LINE_BYTES(LINE_BYTES), .COMMAND_SLOTS(COMMAND_SLOTS)) u_dp (
		.clk, .arst_n, .rx_byte(rx.data), .cmd, .msg_sel, .seed(seed_q),
		.cmd_hashes(hashes_q), .slot_en(enable_q), .sts, .msg_out, .hash_out, .mask_out
	);

	lecmd_ctrl u_ctrl (
		.clk, .arst_n, .in_valid(rx.valid), .in_ready(rx.ready), .rx_byte(rx.data),
		.sts, .cmd, .msg_sel, .out_load, .out_kind, .out_last, .out_use_msg,
		.out_lit, .out_free
	);

	// output register
	logic        ov_q;
	logic [1:0]  kind_q;
	logic [7:0]  tx_q;
	logic [5:0]  mask_q;
	logic [31:0] hash_q;
	logic        last_q;

	assign out_free = !ov_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q <= out_kind;
			last_q <= out_last;
			tx_q   <= (out_kind != lecmd_pkg::KIND_TX) ? 8'd0 :
				(out_use_msg ? msg_out : out_lit);
			mask_q <= (out_kind == lecmd_pkg::KIND_FOUND) ? mask_out : 6'd0;
			hash_q <= (out_kind != lecmd_pkg::KIND_TX) ? hash_out : 32'd0;
		end
	end

	assign res.valid           = ov_q;
	assign res.data.kind       = kind_q;
	assign res.data.tx_byte    = tx_q;
	assign res.data.match_mask = mask_q;
	assign res.data.token_hash = hash_q;
	assign res.data.last       = last_q;

`ifndef SYNTH
	a_found_mask: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && kind_q == lecmd_pkg::KIND_FOUND |-> mask_q != 6'd0)
		else $error("found without match");
	a_tx_clean: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && kind_q == lecmd_pkg::KIND_TX |-> hash_q == 32'd0 && mask_q == 6'd0)
		else $error("transmit item carries hash");
	a_found_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && kind_q == lecmd_pkg::KIND_FOUND |-> last_q)
		else $error("found item not last");
`endif
endmodule
